// ===== rtl/core/srcls_pkg.sv =====
// ----------------------------------------------------------------------------
// srcls_pkg
// Shared types and constants of the scan reply classifier.
// ----------------------------------------------------------------------------
package srcls_pkg;

   localparam int DATA_WIDTH       = 8;
   localparam int STATE_WIDTH      = 3;
   localparam int CSR_INDEX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH   = 16;
   localparam int PORT_WIDTH       = 16;
   localparam int MODE_WIDTH       = 3;
   localparam int OFFSET_WIDTH     = 17;
   localparam int HDR_WORDS_WIDTH  = 4;
   localparam int POS_WIDTH        = 8;

   localparam int MAX_FRAME_BYTES   = 65535;
   localparam int LINK_HEADER_BYTES = 14;
   localparam int ICMP_HEADER_BYTES = 8;
   localparam int EMBEDDED_MIN_BYTES = 8;
   localparam int IPV4_MIN_BYTES    = 20;
   localparam int TCP_MIN_BYTES     = 20;
   localparam int IP_PROTO_POS      = 9;
   localparam int TCP_CTRL_POS      = 13;

   typedef logic [DATA_WIDTH-1:0]      data_type;
   typedef logic [STATE_WIDTH-1:0]     port_state_type;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;
   typedef logic [CSR_DATA_WIDTH-1:0]  csr_data_type;
   typedef logic [PORT_WIDTH-1:0]      port_type;
   typedef logic [MODE_WIDTH-1:0]      mode_type;
   typedef logic [OFFSET_WIDTH-1:0]    offset_type;
   typedef logic [HDR_WORDS_WIDTH-1:0] hdr_words_type;
   typedef logic [POS_WIDTH-1:0]       pos_type;

   // register indexes
   localparam csr_index_type CSR_PROBE_DEST   = 2'd0;
   localparam csr_index_type CSR_PROBE_SOURCE = 2'd1;
   localparam csr_index_type CSR_SCAN_MODE    = 2'd2;

   // scan modes
   localparam mode_type MODE_SYN = 3'd0;
   localparam mode_type MODE_ACK = 3'd2;

   // port states
   localparam port_state_type ST_UNKNOWN    = 3'd0;
   localparam port_state_type ST_OPEN       = 3'd1;
   localparam port_state_type ST_CLOSED     = 3'd2;
   localparam port_state_type ST_FILTERED   = 3'd3;
   localparam port_state_type ST_UNFILTERED = 3'd4;

   // header codes
   localparam data_type PROTO_ICMP            = 8'd1;
   localparam data_type PROTO_TCP             = 8'd6;
   localparam data_type ICMP_TYPE_UNREACHABLE = 8'd3;
   localparam data_type FLAGS_SYN_ACK         = 8'h12;
   localparam data_type FLAG_RST              = 8'h04;

   typedef struct packed {
      port_type probe_dest_port;
      port_type probe_source_port;
      mode_type scan_mode;
   } cfg_type;

endpackage

// ===== rtl/core/srcls_ifs.sv =====
// ----------------------------------------------------------------------------
// srcls_req_if / srcls_rsp_if
// Valid/ready channels for frame bytes in and port states out.
// ----------------------------------------------------------------------------
interface srcls_req_if;
   logic                       valid;
   logic                       ready;
   logic [srcls_pkg::DATA_WIDTH-1:0] data_byte;
   logic                       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface srcls_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [srcls_pkg::STATE_WIDTH-1:0] port_state;

   modport source (output valid, output port_state, input ready);
   modport sink   (input valid, input port_state, output ready);
endinterface

// ===== rtl/core/scan_reply_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// scan_reply_classifier_unit
// Classifies captured replies to a port-scan probe as open, closed, filtered,
// unfiltered or unknown.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle from the link header on; one port state
// follows every byte marked last, passing through the input register, then
// the result register. Ready drops only while a last byte waits for a
// result register that is still full. Program target port, probe source
// port and scan mode between frames.
module scan_reply_classifier_unit (
   input  logic                     clock,
   input  logic                     reset,
   srcls_req_if.sink                req,
   srcls_rsp_if.source              rsp,
   input  logic                     csr_write_enable,
   input  srcls_pkg::csr_index_type csr_index,
   input  srcls_pkg::csr_data_type  csr_write_data
);
   import srcls_pkg::*;

   cfg_type        cfg;
   logic           out_free;
   logic           dec_valid;
   port_state_type dec_state;

   srcls_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   srcls_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req.valid),
      .in_ready     (req.ready),
      .in_data_byte (req.data_byte),
      .in_last_byte (req.last_byte),
      .out_free     (out_free),
      .cfg          (cfg),
      .dec_valid    (dec_valid),
      .dec_state    (dec_state)
   );

   srcls_out_stage u_out (
      .clock          (clock),
      .reset          (reset),
      .dec_valid      (dec_valid),
      .dec_state      (dec_state),
      .out_free       (out_free),
      .rsp_valid      (rsp.valid),
      .rsp_ready      (rsp.ready),
      .rsp_port_state (rsp.port_state)
   );

endmodule

// ===== rtl/core/srcls_csr.sv =====
// ----------------------------------------------------------------------------
// srcls_csr
// Probe configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module srcls_csr (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  srcls_pkg::csr_index_type csr_index,
   input  srcls_pkg::csr_data_type  csr_write_data,
   output srcls_pkg::cfg_type       cfg
);
   import srcls_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PROBE_DEST:   cfg_in.probe_dest_port   = csr_write_data[PORT_WIDTH-1:0];
            CSR_PROBE_SOURCE: cfg_in.probe_source_port = csr_write_data[PORT_WIDTH-1:0];
            CSR_SCAN_MODE:    cfg_in.scan_mode         = csr_write_data[MODE_WIDTH-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/srcls_parse.sv =====
// ----------------------------------------------------------------------------
// srcls_parse
// Input register and frame parser: tracks header fields byte by byte and
// classifies the reply when the last byte of a frame advances.
// ----------------------------------------------------------------------------
module srcls_parse (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  srcls_pkg::data_type       in_data_byte,
   input  logic                      in_last_byte,
   input  logic                      out_free,
   input  srcls_pkg::cfg_type        cfg,
   output logic                      dec_valid,
   output srcls_pkg::port_state_type dec_state
);
   import srcls_pkg::*;

   typedef struct packed {
      offset_type    byte_offset;
      hdr_words_type outer_header_words;
      data_type      outer_protocol;
      hdr_words_type inner_header_words;
      data_type      inner_protocol;
      data_type      icmp_kind;
      port_type      seen_first_port;
      port_type      seen_second_port;
      data_type      tcp_flag_bits;
      port_type      inner_src_port;
      port_type      inner_dst_port;
   } frame_type;

   logic      s1_valid_ff;
   data_type  s1_byte_ff;
   logic      s1_last_ff;
   logic      s1_fire;

   frame_type frame_ff;
   frame_type frame_in;
   frame_type upd;

   offset_type p;
   logic       take;
   pos_type    l4;
   pos_type    it;
   offset_type l4_ext;
   offset_type it_ext;

   function automatic logic hit(offset_type pos, pos_type where);
      return pos == offset_type'(where);
   endfunction

   assign s1_fire  = s1_valid_ff && (!s1_last_ff || out_free);
   assign in_ready = !s1_valid_ff || s1_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (in_ready) begin
         s1_valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         s1_byte_ff <= in_data_byte;
         s1_last_ff <= in_last_byte;
      end
   end

   // field capture for the byte at offset p
   always_comb begin
      p    = frame_ff.byte_offset;
      take = p < offset_type'(MAX_FRAME_BYTES);
      upd  = frame_ff;

      if (take && hit(p, pos_type'(LINK_HEADER_BYTES))) begin
         upd.outer_header_words = s1_byte_ff[HDR_WORDS_WIDTH-1:0];
      end
      if (take && hit(p, pos_type'(LINK_HEADER_BYTES + IP_PROTO_POS))) begin
         upd.outer_protocol = s1_byte_ff;
      end
      l4 = pos_type'(LINK_HEADER_BYTES) + {2'b00, upd.outer_header_words, 2'b00};

      if (take && hit(p, l4)) begin
         upd.seen_first_port[15:8] = s1_byte_ff;
         upd.icmp_kind             = s1_byte_ff;
      end
      if (take && hit(p, l4 + 8'd1)) upd.seen_first_port[7:0]  = s1_byte_ff;
      if (take && hit(p, l4 + 8'd2)) upd.seen_second_port[15:8] = s1_byte_ff;
      if (take && hit(p, l4 + 8'd3)) upd.seen_second_port[7:0]  = s1_byte_ff;
      if (take && hit(p, l4 + pos_type'(TCP_CTRL_POS))) upd.tcp_flag_bits = s1_byte_ff;
      if (take && hit(p, l4 + pos_type'(ICMP_HEADER_BYTES))) begin
         upd.inner_header_words = s1_byte_ff[HDR_WORDS_WIDTH-1:0];
      end
      if (take && hit(p, l4 + pos_type'(ICMP_HEADER_BYTES + IP_PROTO_POS))) begin
         upd.inner_protocol = s1_byte_ff;
      end
      it = l4 + pos_type'(ICMP_HEADER_BYTES) + {2'b00, upd.inner_header_words, 2'b00};

      if (take && hit(p, it))         upd.inner_src_port[15:8] = s1_byte_ff;
      if (take && hit(p, it + 8'd1))  upd.inner_src_port[7:0]  = s1_byte_ff;
      if (take && hit(p, it + 8'd2))  upd.inner_dst_port[15:8] = s1_byte_ff;
      if (take && hit(p, it + 8'd3))  upd.inner_dst_port[7:0]  = s1_byte_ff;

      if (take) upd.byte_offset = p + offset_type'(1);
   end

   // classify on the updated fields, with the updated count as length
   always_comb begin
      l4_ext    = offset_type'(l4);
      it_ext    = offset_type'(it);
      dec_state = ST_UNKNOWN;
      if (upd.byte_offset < offset_type'(LINK_HEADER_BYTES + IPV4_MIN_BYTES)) begin
         dec_state = ST_UNKNOWN;
      end else if (upd.outer_protocol == PROTO_TCP) begin
         if (upd.byte_offset < l4_ext + offset_type'(TCP_MIN_BYTES)) begin
            dec_state = ST_UNKNOWN;
         end else if (upd.seen_first_port != cfg.probe_dest_port ||
                      upd.seen_second_port != cfg.probe_source_port) begin
            dec_state = ST_UNKNOWN;
         end else if (cfg.scan_mode == MODE_SYN &&
                      (upd.tcp_flag_bits & FLAGS_SYN_ACK) == FLAGS_SYN_ACK) begin
            dec_state = ST_OPEN;
         end else if ((upd.tcp_flag_bits & FLAG_RST) == '0) begin
            dec_state = ST_UNKNOWN;
         end else if (cfg.scan_mode == MODE_ACK) begin
            dec_state = ST_UNFILTERED;
         end else begin
            dec_state = ST_CLOSED;
         end
      end else if (upd.outer_protocol == PROTO_ICMP) begin
         if (upd.byte_offset < l4_ext + offset_type'(ICMP_HEADER_BYTES + IPV4_MIN_BYTES) ||
             upd.icmp_kind != ICMP_TYPE_UNREACHABLE ||
             upd.inner_protocol != PROTO_TCP ||
             it_ext + offset_type'(EMBEDDED_MIN_BYTES) > upd.byte_offset ||
             upd.inner_src_port != cfg.probe_source_port ||
             upd.inner_dst_port != cfg.probe_dest_port) begin
            dec_state = ST_UNKNOWN;
         end else begin
            dec_state = ST_FILTERED;
         end
      end
   end

   assign dec_valid = s1_fire && s1_last_ff;

   always_comb begin
      frame_in = frame_ff;
      if (s1_fire) begin
         frame_in = s1_last_ff ? '0 : upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
      end else begin
         frame_ff <= frame_in;
      end
   end

   a_offset_bound: assert property (@(posedge clock) disable iff (reset)
      frame_ff.byte_offset <= offset_type'(MAX_FRAME_BYTES))
      else $error("byte offset past capture limit");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      dec_valid |=> frame_ff.byte_offset == '0 && frame_ff.outer_protocol == '0)
      else $error("frame state not cleared after last byte");

   a_result_room: assert property (@(posedge clock) disable iff (reset)
      dec_valid |-> out_free)
      else $error("result issued without room in result register");

endmodule

// ===== rtl/core/srcls_out_stage.sv =====
// ----------------------------------------------------------------------------
// srcls_out_stage
// Result register between the parser and the response channel.
// ----------------------------------------------------------------------------
module srcls_out_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      dec_valid,
   input  srcls_pkg::port_state_type dec_state,
   output logic                      out_free,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output srcls_pkg::port_state_type rsp_port_state
);
   import srcls_pkg::*;

   logic           out_valid_ff;
   port_state_type out_state_ff;

   assign out_free = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (dec_valid) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (dec_valid) begin
         out_state_ff <= dec_state;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_port_state = out_state_ff;

   a_state_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_state_ff <= ST_UNFILTERED)
      else $error("port state code out of range");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |-> !dec_valid)
      else $error("pending result overwritten");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      dec_valid |=> out_valid_ff && out_state_ff == $past(dec_state))
      else $error("result not loaded");

endmodule

// ===== tb/tb_scan_reply_classifier_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scan_reply_classifier_unit
// Feeds captured reply frames byte by byte into the scan reply classifier,
// predicts the port state of each frame from the link, IPv4, TCP and
// ICMP-embedded headers, and checks every result transfer in order. Covers
// short frames, the scan modes, short header lengths, back-pressure and
// random traffic with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_scan_reply_classifier_unit;
   import srcls_pkg::*;

   localparam int CLOCK_PERIOD  = 20;
   localparam int WORD_BYTES    = 4;
   localparam int STALL_LIMIT   = 5000;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 4;

   localparam csr_index_type CSR_UNUSED = 2'd3;

   localparam mode_type MODE_NULL      = 3'd1;
   localparam mode_type MODE_FIN       = 3'd3;
   localparam mode_type MODE_XMAS      = 3'd4;
   localparam mode_type MODE_UNDEFINED = 3'd6;

   localparam data_type       FLAG_ACK        = 8'h10;
   localparam logic [3:0]     IPV4_VERSION    = 4'd4;
   localparam hdr_words_type  IHL_PLAIN       = 4'd5;

   typedef struct {
      int            count;
      hdr_words_type outer_words;
      data_type      outer_proto;
      data_type      icmp_kind;
      hdr_words_type inner_words;
      data_type      inner_proto;
      port_type      reply_src;
      port_type      reply_dst;
      data_type      flag_bits;
      port_type      inner_src;
      port_type      inner_dst;
   } reply_fields_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_write_enable;
   csr_index_type csr_index;
   csr_data_type  csr_write_data;

   srcls_req_if req_if ();
   srcls_rsp_if rsp_if ();

   scan_reply_classifier_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_if),
      .rsp              (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   cfg_type          probe_cfg;
   reply_fields_type reply;
   port_state_type   expected_states[$];
   data_type         frame_buf[$];
   int               mismatches;
   int               idle_cycles;
   int               stall_left;
   bit               gaps_on;
   bit               hold_request;

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Reply predictor
   // ---------------------------------------------------------------------
   function automatic void take_reply_byte(data_type b);
      int p;
      int l4;
      int it;
      p = reply.count;
      if (p == LINK_HEADER_BYTES) reply.outer_words = b[3:0];
      if (p == LINK_HEADER_BYTES + IP_PROTO_POS) reply.outer_proto = b;
      l4 = LINK_HEADER_BYTES + WORD_BYTES * reply.outer_words;
      if (p == l4) begin
         reply.reply_src[15:8] = b;
         reply.icmp_kind = b;
      end
      if (p == l4 + 1) reply.reply_src[7:0] = b;
      if (p == l4 + 2) reply.reply_dst[15:8] = b;
      if (p == l4 + 3) reply.reply_dst[7:0] = b;
      if (p == l4 + TCP_CTRL_POS) reply.flag_bits = b;
      if (p == l4 + ICMP_HEADER_BYTES) reply.inner_words = b[3:0];
      if (p == l4 + ICMP_HEADER_BYTES + IP_PROTO_POS) reply.inner_proto = b;
      it = l4 + ICMP_HEADER_BYTES + WORD_BYTES * reply.inner_words;
      if (p == it) reply.inner_src[15:8] = b;
      if (p == it + 1) reply.inner_src[7:0] = b;
      if (p == it + 2) reply.inner_dst[15:8] = b;
      if (p == it + 3) reply.inner_dst[7:0] = b;
   endfunction

   function automatic port_state_type classify_reply(int len);
      int l4;
      l4 = LINK_HEADER_BYTES + WORD_BYTES * reply.outer_words;
      if (len < LINK_HEADER_BYTES + IPV4_MIN_BYTES) return ST_UNKNOWN;
      if (reply.outer_proto == PROTO_TCP) begin
         if (len < l4 + TCP_MIN_BYTES) return ST_UNKNOWN;
         if (reply.reply_src != probe_cfg.probe_dest_port ||
             reply.reply_dst != probe_cfg.probe_source_port) return ST_UNKNOWN;
         if (probe_cfg.scan_mode == MODE_SYN &&
             (reply.flag_bits & FLAGS_SYN_ACK) == FLAGS_SYN_ACK) return ST_OPEN;
         if ((reply.flag_bits & FLAG_RST) == 0) return ST_UNKNOWN;
         return (probe_cfg.scan_mode == MODE_ACK) ? ST_UNFILTERED : ST_CLOSED;
      end
      if (reply.outer_proto == PROTO_ICMP) begin
         if (len < l4 + ICMP_HEADER_BYTES + IPV4_MIN_BYTES) return ST_UNKNOWN;
         if (reply.icmp_kind != ICMP_TYPE_UNREACHABLE) return ST_UNKNOWN;
         if (reply.inner_proto != PROTO_TCP) return ST_UNKNOWN;
         if (l4 + ICMP_HEADER_BYTES + WORD_BYTES * reply.inner_words + EMBEDDED_MIN_BYTES > len)
            return ST_UNKNOWN;
         if (reply.inner_src != probe_cfg.probe_source_port ||
             reply.inner_dst != probe_cfg.probe_dest_port) return ST_UNKNOWN;
         return ST_FILTERED;
      end
      return ST_UNKNOWN;
   endfunction

   always @(posedge clock) begin : predict_and_check
      port_state_type want;
      if (reset) begin
         probe_cfg = '0;
         reply = '{default: 0};
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_states.size() == 0) begin
               $display("%0t: unexpected port state transfer: expected none, actual %0d",
                        $time, rsp_if.port_state);
               mismatches++;
            end else begin
               want = expected_states.pop_front();
               if (rsp_if.port_state !== want) begin
                  $display("%0t: port_state mismatch: expected %0d, actual %0d",
                           $time, want, rsp_if.port_state);
                  mismatches++;
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            if (reply.count < MAX_FRAME_BYTES) begin
               take_reply_byte(req_if.data_byte);
               reply.count++;
            end
            if (req_if.last_byte) begin
               expected_states.push_back(classify_reply(reply.count));
               reply = '{default: 0};
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_PROBE_DEST:   probe_cfg.probe_dest_port = csr_write_data;
               CSR_PROBE_SOURCE: probe_cfg.probe_source_port = csr_write_data;
               CSR_SCAN_MODE:    probe_cfg.scan_mode = csr_write_data[MODE_WIDTH-1:0];
               default: ;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_scan_reply_classifier_unit failed");
            $finish;
         end
      end
   end

   // hold off the result channel on request, else stall in random bursts while gaps are on
   always @(negedge clock) begin
      if (hold_request) begin
         stall_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 15) - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------
   task automatic send_byte(data_type b, logic last);
      @(negedge clock);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= b;
      req_if.last_byte <= last;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic send_frame();
      foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
   endtask

   task automatic settle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_states.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, csr_data_type value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
   endtask

   task automatic configure(port_type target, port_type source, csr_data_type mode_word);
      settle();
      write_reg(CSR_PROBE_DEST, target);
      write_reg(CSR_PROBE_SOURCE, source);
      write_reg(CSR_SCAN_MODE, mode_word);
      write_reg(CSR_UNUSED, csr_data_type'($urandom));
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Frame builders
   // ---------------------------------------------------------------------
   function automatic void fill_random(int len);
      frame_buf.delete();
      repeat (len) frame_buf.push_back(data_type'($urandom));
   endfunction

   function automatic void poke(int pos, data_type b);
      if (pos < frame_buf.size()) frame_buf[pos] = b;
   endfunction

   function automatic int tcp_len(hdr_words_type ihl);
      return LINK_HEADER_BYTES + WORD_BYTES * ihl + TCP_MIN_BYTES;
   endfunction

   function automatic int icmp_len(hdr_words_type ihl, hdr_words_type inner_ihl);
      int l4;
      int a;
      int b;
      l4 = LINK_HEADER_BYTES + WORD_BYTES * ihl;
      a = l4 + ICMP_HEADER_BYTES + IPV4_MIN_BYTES;
      b = l4 + ICMP_HEADER_BYTES + WORD_BYTES * inner_ihl + EMBEDDED_MIN_BYTES;
      return (a > b) ? a : b;
   endfunction

   function automatic void build_tcp(int len, hdr_words_type ihl, port_type sport,
                                     port_type dport, data_type flags);
      int l4;
      l4 = LINK_HEADER_BYTES + WORD_BYTES * ihl;
      fill_random(len);
      poke(LINK_HEADER_BYTES, {IPV4_VERSION, ihl});
      poke(LINK_HEADER_BYTES + IP_PROTO_POS, PROTO_TCP);
      poke(l4, sport[15:8]);
      poke(l4 + 1, sport[7:0]);
      poke(l4 + 2, dport[15:8]);
      poke(l4 + 3, dport[7:0]);
      poke(l4 + TCP_CTRL_POS, flags);
   endfunction

   function automatic void build_icmp(int len, hdr_words_type ihl, data_type kind,
                                      hdr_words_type inner_ihl, data_type inner_proto,
                                      port_type isrc, port_type idst);
      int l4;
      int it;
      l4 = LINK_HEADER_BYTES + WORD_BYTES * ihl;
      it = l4 + ICMP_HEADER_BYTES + WORD_BYTES * inner_ihl;
      fill_random(len);
      poke(LINK_HEADER_BYTES, {IPV4_VERSION, ihl});
      poke(LINK_HEADER_BYTES + IP_PROTO_POS, PROTO_ICMP);
      poke(l4, kind);
      poke(l4 + ICMP_HEADER_BYTES, {IPV4_VERSION, inner_ihl});
      poke(l4 + ICMP_HEADER_BYTES + IP_PROTO_POS, inner_proto);
      poke(it, isrc[15:8]);
      poke(it + 1, isrc[7:0]);
      poke(it + 2, idst[15:8]);
      poke(it + 3, idst[7:0]);
   endfunction

   task automatic send_tcp(int len, hdr_words_type ihl, port_type sport, port_type dport,
                           data_type flags);
      build_tcp(len, ihl, sport, dport, flags);
      send_frame();
   endtask

   task automatic send_icmp(int len, hdr_words_type ihl, data_type kind,
                            hdr_words_type inner_ihl, data_type inner_proto,
                            port_type isrc, port_type idst);
      build_icmp(len, ihl, kind, inner_ihl, inner_proto, isrc, idst);
      send_frame();
   endtask

   function automatic port_type pick_port();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return '1;
         default: return port_type'($urandom);
      endcase
   endfunction

   function automatic void build_random_reply();
      int            pick;
      int            len;
      hdr_words_type ihl;
      hdr_words_type inner_ihl;
      port_type      a;
      port_type      b;
      data_type      flags;
      data_type      kind;
      data_type      iproto;
      pick = $urandom_range(0, 9);
      ihl  = ($urandom_range(0, 7) == 0) ? hdr_words_type'($urandom_range(0, 15)) : IHL_PLAIN;
      if (pick < 6) begin
         a = probe_cfg.probe_dest_port;
         b = probe_cfg.probe_source_port;
         if ($urandom_range(0, 5) == 0) a = port_type'($urandom);
         if ($urandom_range(0, 5) == 0) b = port_type'($urandom);
         case ($urandom_range(0, 3))
            0:       flags = FLAGS_SYN_ACK;
            1:       flags = FLAG_RST;
            2:       flags = FLAG_RST | FLAG_ACK;
            default: flags = data_type'($urandom);
         endcase
         len = tcp_len(ihl) + $urandom_range(0, 12);
         if ($urandom_range(0, 7) == 0) len = $urandom_range(1, len);
         build_tcp(len, ihl, a, b, flags);
      end else if (pick < 9) begin
         inner_ihl = ($urandom_range(0, 5) == 0) ? hdr_words_type'($urandom_range(0, 15))
                                                 : IHL_PLAIN;
         kind   = ($urandom_range(0, 5) == 0) ? data_type'($urandom) : ICMP_TYPE_UNREACHABLE;
         iproto = ($urandom_range(0, 6) == 0) ? data_type'($urandom) : PROTO_TCP;
         a = probe_cfg.probe_source_port;
         b = probe_cfg.probe_dest_port;
         if ($urandom_range(0, 5) == 0) a = port_type'($urandom);
         if ($urandom_range(0, 5) == 0) b = port_type'($urandom);
         len = icmp_len(ihl, inner_ihl) + $urandom_range(0, 8);
         if ($urandom_range(0, 7) == 0) len = $urandom_range(1, len);
         build_icmp(len, ihl, kind, inner_ihl, iproto, a, b);
      end else begin
         fill_random($urandom_range(1, 80));
      end
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_reset_config();
      send_tcp(tcp_len(IHL_PLAIN), IHL_PLAIN, '0, '0, FLAGS_SYN_ACK);
   endtask

   task automatic test_short_frames();
      configure(16'h1234, 16'h8000, MODE_SYN);
      fill_random(1);
      send_frame();
      send_tcp(LINK_HEADER_BYTES + IPV4_MIN_BYTES - 1, 4'd0, 16'h1234, 16'h8000, FLAG_RST);
      send_tcp(LINK_HEADER_BYTES + IPV4_MIN_BYTES, 4'd0, 16'h1234, 16'h8000, FLAG_RST);
   endtask

   task automatic test_tcp_replies();
      configure(16'h0050, 16'hC001, MODE_SYN);
      send_tcp(tcp_len(IHL_PLAIN), IHL_PLAIN, 16'h0050, 16'hC001, FLAG_ACK);
      send_tcp(tcp_len(IHL_PLAIN), IHL_PLAIN, 16'h0051, 16'hC001, FLAGS_SYN_ACK);
   endtask

   task automatic test_scan_modes();
      mode_type modes[4] = '{MODE_SYN, MODE_ACK, MODE_XMAS, MODE_UNDEFINED};
      foreach (modes[k]) begin
         configure(16'h0016, 16'h9abc, {13'($urandom), modes[k]});
         send_tcp(tcp_len(IHL_PLAIN), IHL_PLAIN, 16'h0016, 16'h9abc,
                  FLAGS_SYN_ACK | FLAG_RST);
      end
   endtask

   task automatic test_icmp_unreachable();
      configure(16'hFFFF, 16'h0000, MODE_FIN);
      send_icmp(icmp_len(IHL_PLAIN, IHL_PLAIN), IHL_PLAIN, ICMP_TYPE_UNREACHABLE, IHL_PLAIN,
                PROTO_TCP, 16'h0000, 16'hFFFF);
      send_icmp(icmp_len(IHL_PLAIN, IHL_PLAIN) - 1, IHL_PLAIN, ICMP_TYPE_UNREACHABLE,
                IHL_PLAIN, PROTO_TCP, 16'h0000, 16'hFFFF);
   endtask

   task automatic test_short_header_length();
      hdr_words_type w;
      w = hdr_words_type'($urandom_range(1, 4));
      configure(16'h0303, 16'h0606, MODE_ACK);
      send_tcp(tcp_len(w), w, 16'h0303, 16'h0606, FLAG_RST);
   endtask

   task automatic test_backpressure();
      configure(16'h0101, 16'h0202, MODE_NULL);
      hold_request = 1'b1;
      repeat (10) begin
         fill_random($urandom_range(1, 3));
         send_frame();
      end
   endtask

   task automatic test_random_traffic();
      int frames;
      int bytes;
      frames = 0;
      bytes  = 0;
      while (frames < 3 || bytes < 80) begin
         if (frames % 2 == 0)
            configure(pick_port(), pick_port(), {13'($urandom), 3'($urandom_range(0, 7))});
         build_random_reply();
         send_frame();
         frames++;
         bytes += frame_buf.size();
      end
   endtask

   task automatic test_full_rate();
      configure(pick_port(), pick_port(), csr_data_type'($urandom_range(0, 7)));
      gaps_on = 1'b0;
      repeat (2) begin
         build_random_reply();
         send_frame();
      end
   endtask

   initial begin
      csr_write_enable = 1'b0;
      csr_index        = CSR_PROBE_DEST;
      csr_write_data   = '0;
      req_if.valid     = 1'b0;
      req_if.data_byte = '0;
      req_if.last_byte = 1'b0;
      rsp_if.ready     = 1'b0;
      gaps_on          = 1'b1;
      hold_request     = 1'b0;
      stall_left       = 0;
      mismatches       = 0;
      idle_cycles      = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_config();
      test_short_frames();
      test_tcp_replies();
      test_scan_modes();
      test_icmp_unreachable();
      test_short_header_length();
      test_backpressure();
      test_random_traffic();
      test_full_rate();
      settle();

      if (mismatches == 0) begin
         $display("tb_scan_reply_classifier_unit passed");
      end else begin
         $display("tb_scan_reply_classifier_unit failed");
      end
      $finish;
   end

endmodule
